@@ src/qet_pkg.sv @@
// ----------------------------------------------------------------------------
// qet_pkg: shared definitions for the quadratic escape-time block
// Widths, fixed-point constants, register indexes and the configuration
// bundle that the top level hands to the iteration core.
// ----------------------------------------------------------------------------
package qet_pkg;

    // Coordinate and count formats.
    localparam int COORD_WIDTH     = 32;
    localparam int FRAC_BITS       = 28;
    localparam int COUNT_WIDTH     = 16;
    localparam int PROD_WIDTH      = 2 * COORD_WIDTH;
    localparam int CFG_INDEX_WIDTH = 8;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_JULIA_MODE      = CFG_INDEX_WIDTH'(0);
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ITERATION_LIMIT = CFG_INDEX_WIDTH'(1);
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_JULIA_C_RE      = CFG_INDEX_WIDTH'(2);
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_JULIA_C_IM      = CFG_INDEX_WIDTH'(3);

    // 0.54 in fixed point, rounded to nearest.
    localparam logic [63:0] ONE_FIX = 64'd1 << FRAC_BITS;
    localparam logic [63:0] C054_FIX =
        (ONE_FIX / 64'd100) * 64'd54 + ((ONE_FIX % 64'd100) * 64'd54 + 64'd50) / 64'd100;

    // Reset values of the registers.
    localparam logic [COUNT_WIDTH-1:0] ITERATION_LIMIT_RESET = COUNT_WIDTH'(256);
    localparam logic signed [COORD_WIDTH-1:0] JULIA_C_IM_RESET = COORD_WIDTH'(C054_FIX);
    localparam logic signed [COORD_WIDTH-1:0] JULIA_C_RE_RESET = -JULIA_C_IM_RESET;

    // Configuration bundle seen by the core.
    typedef struct packed {
        logic                          julia_mode;
        logic [COUNT_WIDTH-1:0]        iteration_limit;
        logic signed [COORD_WIDTH-1:0] julia_c_re;
        logic signed [COORD_WIDTH-1:0] julia_c_im;
    } qet_cfg_t;

endpackage

@@ src/qet_mul.sv @@
// ----------------------------------------------------------------------------
// qet_mul: shared signed multiplier
// One signed coordinate-by-coordinate multiplier with a registered product.
// The core time-shares it for a*a, b*b and a*b.
// ----------------------------------------------------------------------------
module qet_mul (
    input  logic                                  clk,
    input  logic signed [qet_pkg::COORD_WIDTH-1:0] op_a,
    input  logic signed [qet_pkg::COORD_WIDTH-1:0] op_b,
    output logic signed [qet_pkg::PROD_WIDTH-1:0]  prod
);
    import qet_pkg::*;

    logic signed [PROD_WIDTH-1:0] prod_reg;

    // Full-width product, registered for the next step of the sequencer.
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_WIDTH'(op_a) * PROD_WIDTH'(op_b);
    end

    assign prod = prod_reg;

endmodule

@@ src/qet_core.sv @@
// ----------------------------------------------------------------------------
// qet_core: escape-time iteration sequencer
// Holds z and c, drives the shared multiplier through a*a, b*b and a*b,
// runs the escape test and the saturating update, and counts iterations.
// ----------------------------------------------------------------------------
module qet_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  qet_pkg::qet_cfg_t                     cfg,
    input  logic                                  point_valid,
    output logic                                  point_ready,
    input  logic signed [qet_pkg::COORD_WIDTH-1:0] point_re,
    input  logic signed [qet_pkg::COORD_WIDTH-1:0] point_im,
    output logic                                  res_valid,
    input  logic                                  res_ready,
    output logic [qet_pkg::COUNT_WIDTH-1:0]        res_count
);
    import qet_pkg::*;

    localparam int SUM_WIDTH = COORD_WIDTH + 2;
    localparam int SQ_WIDTH  = PROD_WIDTH + 1;

    localparam logic signed [COORD_WIDTH-1:0] TWO     = COORD_WIDTH'(1) << (FRAC_BITS + 1);
    localparam logic signed [COORD_WIDTH-1:0] NEG_TWO = -TWO;
    localparam logic [SQ_WIDTH-1:0]           FOUR    = SQ_WIDTH'(1) << (2 * FRAC_BITS + 2);
    localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_MUL_AA = 6'b000010,
        S_MUL_BB = 6'b000100,
        S_MUL_AB = 6'b001000,
        S_STEP   = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    // Saturating add of a scaled product and a coordinate.
    function automatic logic signed [COORD_WIDTH-1:0] sat_add(
        input logic signed [COORD_WIDTH:0]   x,
        input logic signed [COORD_WIDTH-1:0] c
    );
        logic signed [SUM_WIDTH-1:0] s;
        s = SUM_WIDTH'(x) + SUM_WIDTH'(c);
        if (s[SUM_WIDTH-1] && !(s[SUM_WIDTH-2] && s[COORD_WIDTH-1]))
            sat_add = COORD_MIN;
        else if (!s[SUM_WIDTH-1] && (s[SUM_WIDTH-2] || s[COORD_WIDTH-1]))
            sat_add = COORD_MAX;
        else
            sat_add = s[COORD_WIDTH-1:0];
    endfunction

    state_t                        state_reg, state_next;
    logic signed [COORD_WIDTH-1:0] a_reg, a_next;
    logic signed [COORD_WIDTH-1:0] b_reg, b_next;
    logic signed [COORD_WIDTH-1:0] cr_reg, cr_next;
    logic signed [COORD_WIDTH-1:0] ci_reg, ci_next;
    logic [COUNT_WIDTH-1:0]        count_reg, count_next;
    logic [COUNT_WIDTH-1:0]        limit_reg, limit_next;
    logic signed [PROD_WIDTH-1:0]  aa_reg, aa_next;
    logic signed [PROD_WIDTH-1:0]  bb_reg, bb_next;

    logic signed [COORD_WIDTH-1:0] mul_a, mul_b;
    logic signed [PROD_WIDTH-1:0]  mul_prod;
    logic                          stop_early;
    logic [SQ_WIDTH-1:0]           mag_sq;
    logic                          escaped;
    logic signed [PROD_WIDTH-1:0]  diff_sq;
    logic signed [PROD_WIDTH-1:0]  re_wide, im_wide;
    logic signed [COORD_WIDTH-1:0] re_new, im_new;

    qet_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_prod)
    );

    // Operand selection for the shared multiplier.
    always_comb
    begin
        unique case (state_reg)
            S_MUL_BB:
            begin
                mul_a = b_reg;
                mul_b = b_reg;
            end
            S_MUL_AB:
            begin
                mul_a = a_reg;
                mul_b = b_reg;
            end
            default:
            begin
                mul_a = a_reg;
                mul_b = a_reg;
            end
        endcase
    end

    // Limit reached or a coordinate already at or beyond magnitude two.
    assign stop_early = (count_reg >= limit_reg) ||
                        (a_reg >= TWO) || (a_reg <= NEG_TWO) ||
                        (b_reg >= TWO) || (b_reg <= NEG_TWO);

    // Escape test on the exact squared magnitude; a*b arrives from the multiplier.
    assign mag_sq  = {1'b0, aa_reg} + {1'b0, bb_reg};
    assign escaped = (mag_sq >= FOUR);

    // Next z: floor-scaled real and imaginary parts plus c, saturated.
    assign diff_sq = aa_reg - bb_reg;
    assign re_wide = diff_sq >>> FRAC_BITS;
    assign im_wide = mul_prod >>> (FRAC_BITS - 1);
    assign re_new  = sat_add(re_wide[COORD_WIDTH:0], cr_reg);
    assign im_new  = sat_add(im_wide[COORD_WIDTH:0], ci_reg);

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        cr_next    = cr_reg;
        ci_next    = ci_reg;
        count_next = count_reg;
        limit_next = limit_reg;
        aa_next    = aa_reg;
        bb_next    = bb_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (point_valid)
                begin
                    count_next = '0;
                    limit_next = cfg.iteration_limit;
                    if (cfg.julia_mode)
                    begin
                        a_next  = point_re;
                        b_next  = point_im;
                        cr_next = cfg.julia_c_re;
                        ci_next = cfg.julia_c_im;
                    end
                    else
                    begin
                        a_next  = '0;
                        b_next  = '0;
                        cr_next = point_re;
                        ci_next = point_im;
                    end
                    state_next = S_MUL_AA;
                end
            end
            S_MUL_AA:
            begin
                state_next = stop_early ? S_FINISH : S_MUL_BB;
            end
            S_MUL_BB:
            begin
                aa_next    = mul_prod;
                state_next = S_MUL_AB;
            end
            S_MUL_AB:
            begin
                bb_next    = mul_prod;
                state_next = S_STEP;
            end
            S_STEP:
            begin
                if (escaped)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    a_next     = re_new;
                    b_next     = im_new;
                    count_next = count_reg + COUNT_WIDTH'(1);
                    state_next = S_MUL_AA;
                end
            end
            S_FINISH:
            begin
                if (res_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            limit_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            limit_reg <= limit_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        a_reg  <= a_next;
        b_reg  <= b_next;
        cr_reg <= cr_next;
        ci_reg <= ci_next;
        aa_reg <= aa_next;
        bb_reg <= bb_next;
    end

    assign point_ready = (state_reg == S_IDLE);
    assign res_valid   = (state_reg == S_FINISH);
    assign res_count   = count_reg;

`ifndef SYNTHESIS
    // The count never passes the limit latched with the word.
    a_count_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (count_reg <= limit_reg))
        else $error("iteration count above the latched limit");

    // Each completed iteration adds exactly one to the count.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL_AA && $past(state_reg) == S_STEP)
        |-> (count_reg == COUNT_WIDTH'($past(count_reg) + COUNT_WIDTH'(1))))
        else $error("iteration count did not advance by one");

    // A result only appears after a limit/range test or an escape test.
    a_finish_entry: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> ($past(state_reg) == S_MUL_AA || $past(state_reg) == S_STEP))
        else $error("result raised from an unexpected state");

    // The b*b product is only requested right after a*a.
    a_mul_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL_BB) |-> ($past(state_reg) == S_MUL_AA))
        else $error("multiplier schedule out of order");
`endif

endmodule

@@ src/quadratic_escape_time.sv @@
// ----------------------------------------------------------------------------
// quadratic_escape_time: escape-time counter for z <- z^2 + c
// Channel  Direction  Handshake                 Word
// cfg      in         cfg_valid / cfg_ready     cfg_index, cfg_data
// point    in         point_valid / point_ready point_re, point_im (Q4.28)
// count    out        count_valid / count_ready escape_count
//
// A word is loaded, then each iteration steps through a*a, b*b, a*b and the
// update, and a final test and hand-off close the word.  This schedule is set
// by the single shared 32x32 multiplier, used for a*a, b*b and a*b in turn.
// Reset (rst_n low, asynchronous) restores Mandelbrot mode, a limit of 256 and
// c = (-0.54, 0.54).  A finished count waits in the output register, so a new
// point is taken while the previous count is still unread; the core stalls
// only when a second count is ready before the first has been taken.
// ----------------------------------------------------------------------------
module quadratic_escape_time (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [qet_pkg::CFG_INDEX_WIDTH-1:0]       cfg_index,
    input  logic [qet_pkg::COORD_WIDTH-1:0]           cfg_data,
    input  logic                                      point_valid,
    output logic                                      point_ready,
    input  logic signed [qet_pkg::COORD_WIDTH-1:0]    point_re,
    input  logic signed [qet_pkg::COORD_WIDTH-1:0]    point_im,
    output logic                                      count_valid,
    input  logic                                      count_ready,
    output logic [qet_pkg::COUNT_WIDTH-1:0]           escape_count
);
    import qet_pkg::*;

    qet_cfg_t               cfg_reg, cfg_next;
    logic                   count_valid_reg, count_valid_next;
    logic [COUNT_WIDTH-1:0] escape_count_reg;
    logic                   res_valid;
    logic                   res_ready;
    logic [COUNT_WIDTH-1:0] res_count;

    // Register writes are always taken; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_JULIA_MODE:      cfg_next.julia_mode      = cfg_data[0];
                CFG_ITERATION_LIMIT: cfg_next.iteration_limit = cfg_data[COUNT_WIDTH-1:0];
                CFG_JULIA_C_RE:      cfg_next.julia_c_re      = cfg_data;
                CFG_JULIA_C_IM:      cfg_next.julia_c_im      = cfg_data;
                default:             cfg_next                 = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.julia_mode      <= 1'b0;
            cfg_reg.iteration_limit <= ITERATION_LIMIT_RESET;
            cfg_reg.julia_c_re      <= JULIA_C_RE_RESET;
            cfg_reg.julia_c_im      <= JULIA_C_IM_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    qet_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .point_valid (point_valid),
        .point_ready (point_ready),
        .point_re    (point_re),
        .point_im    (point_im),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_count   (res_count)
    );

    // Output register: takes a count whenever it is empty or being drained.
    assign res_ready = !count_valid_reg || count_ready;

    always_comb
    begin
        count_valid_next = count_valid_reg;
        if (res_valid && res_ready)
            count_valid_next = 1'b1;
        else if (count_ready)
            count_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_valid_reg <= 1'b0;
        else
            count_valid_reg <= count_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
            escape_count_reg <= res_count;
    end

    assign count_valid  = count_valid_reg;
    assign escape_count = escape_count_reg;

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for quadratic_escape_time
// Points go in on the point channel, escape counts come back on the count
// channel. The bench predicts each count with its own fixed-point iteration
// of z <- z^2 + c and checks every count word against the oldest prediction.
// Directed words cover the field extremes, reset settings, register extremes
// and saturation. Random traffic then runs under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb;
    import qet_pkg::*;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic [COUNT_WIDTH-1:0]        count_t;

    // One accepted point together with the count it should produce.
    typedef struct {
        coord_t re;
        coord_t im;
        count_t count;
    } escape_entry_t;

    localparam logic MODE_MANDELBROT = 1'b0;
    localparam logic MODE_JULIA      = 1'b1;

    // Indexes that no register answers to.
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_UNUSED_FIRST = CFG_INDEX_WIDTH'(4);
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_UNUSED_LAST  = '1;

    localparam int     RESET_CYCLES    = 9;
    localparam int     HOLD_OFF_CYCLES = 600;
    localparam int     SETTLE_CYCLES   = 64;
    localparam int     MAX_REPORTS     = 10;
    localparam longint CYCLE_LIMIT     = 10_000_000;

    // Register contents after reset; 0.54 is 144955146 in Q4.28.
    localparam count_t LIMIT_AT_RESET = COUNT_WIDTH'(256);
    localparam coord_t C_RE_AT_RESET  = -32'sd144955146;
    localparam coord_t C_IM_AT_RESET  = 32'sd144955146;

    // Escape bounds and coordinate range.
    localparam longint TWO_FIX   = longint'(1) << (FRAC_BITS + 1);
    localparam longint FOUR_SQ   = longint'(1) << (2 * FRAC_BITS + 2);
    localparam longint COORD_MAX = (longint'(1) << (COORD_WIDTH - 1)) - 1;
    localparam longint COORD_MIN = -(longint'(1) << (COORD_WIDTH - 1));
    localparam coord_t TWO_POS   = coord_t'(TWO_FIX);
    localparam coord_t POS_LIMIT = coord_t'(COORD_MAX);
    localparam coord_t NEG_LIMIT = coord_t'(COORD_MIN);

    logic                       clk         = 1'b0;
    logic                       rst_n       = 1'b0;
    logic                       cfg_valid   = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index   = '0;
    logic [COORD_WIDTH-1:0]     cfg_data    = '0;
    logic                       point_valid = 1'b0;
    logic                       point_ready;
    coord_t                     point_re    = '0;
    coord_t                     point_im    = '0;
    logic                       count_valid;
    logic                       count_ready = 1'b0;
    count_t                     escape_count;

    // Predictor copy of the registers.
    logic   julia_sel  = MODE_MANDELBROT;
    count_t iter_limit = LIMIT_AT_RESET;
    coord_t julia_re   = C_RE_AT_RESET;
    coord_t julia_im   = C_IM_AT_RESET;

    escape_entry_t pending_counts[$];
    escape_entry_t oldest_point;

    int     send_idle_pct  = 0;
    int     recv_stall_pct = 0;
    int     hold_req       = 0;
    logic   rx_hold        = 1'b0;
    longint cycle_count    = 0;
    int     error_count    = 0;
    int     points_sent    = 0;
    int     julia_points   = 0;
    int     reg_writes     = 0;
    count_t max_count_seen = '0;

    quadratic_escape_time u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .point_valid  (point_valid),
        .point_ready  (point_ready),
        .point_re     (point_re),
        .point_im     (point_im),
        .count_valid  (count_valid),
        .count_ready  (count_ready),
        .escape_count (escape_count)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d counts outstanding.",
                     cycle_count, pending_counts.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver: random stalls, forced low during a hold-off.
    always @(posedge clk)
        count_ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);

    // Long receiver hold-off, started each time a test bumps hold_req.
    initial
    begin : hold_off
        int hold_seen;
        hold_seen = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                rx_hold <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                rx_hold <= 1'b0;
            end
        end
    end

    task automatic report_fault(input string what);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("Mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    // Count checker: every count word is matched against the oldest point.
    always @(posedge clk)
    begin
        if (rst_n && count_valid && count_ready)
        begin
            if (pending_counts.size() == 0)
                report_fault($sformatf("count %0d arrived with no point outstanding",
                                       escape_count));
            else
            begin
                oldest_point = pending_counts.pop_front();
                if (escape_count !== oldest_point.count)
                    report_fault($sformatf("point (%0d, %0d): count %0d, expected %0d",
                                           oldest_point.re, oldest_point.im,
                                           escape_count, oldest_point.count));
                if (oldest_point.count > max_count_seen)
                    max_count_seen = oldest_point.count;
            end
        end
    end

    function automatic coord_t saturate_coord(input longint v);
        if (v > COORD_MAX)
            return POS_LIMIT;
        if (v < COORD_MIN)
            return NEG_LIMIT;
        return coord_t'(v);
    endfunction

    // Escape-time count of one point under the current register settings.
    function automatic count_t escape_count_of(input coord_t pt_re, input coord_t pt_im);
        longint      z_re;
        longint      z_im;
        longint      c_re;
        longint      c_im;
        longint      abs_re;
        longint      abs_im;
        longint      sq_re;
        longint      sq_im;
        int unsigned steps;
        if (julia_sel == MODE_JULIA)
        begin
            z_re = pt_re;
            z_im = pt_im;
            c_re = julia_re;
            c_im = julia_im;
        end
        else
        begin
            z_re = 0;
            z_im = 0;
            c_re = pt_re;
            c_im = pt_im;
        end
        steps = 0;
        while (steps < iter_limit)
        begin
            abs_re = (z_re < 0) ? -z_re : z_re;
            abs_im = (z_im < 0) ? -z_im : z_im;
            if (abs_re >= TWO_FIX || abs_im >= TWO_FIX)
                break;
            sq_re = abs_re * abs_re;
            sq_im = abs_im * abs_im;
            if (sq_re + sq_im >= FOUR_SQ)
                break;
            // Arithmetic shifts give the floor; the imaginary part uses the old z_re.
            z_im = saturate_coord(((2 * z_re * z_im) >>> FRAC_BITS) + c_im);
            z_re = saturate_coord(((sq_re - sq_im) >>> FRAC_BITS) + c_re);
            steps++;
        end
        return count_t'(steps);
    endfunction

    function automatic coord_t to_fix(input real v);
        return coord_t'($rtoi(v * (2.0 ** FRAC_BITS)));
    endfunction

    // Mostly inside the escape circle, with some full-range and boundary values.
    function automatic coord_t rand_coord();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 70)
            return coord_t'($urandom) >>> 2;
        if (pick < 80)
            return coord_t'($urandom) >>> 3;
        if (pick < 90)
            return coord_t'($urandom);
        case ($urandom_range(7))
            0:       return '0;
            1:       return coord_t'(1);
            2:       return coord_t'(-1);
            3:       return TWO_POS;
            4:       return -TWO_POS;
            5:       return TWO_POS - coord_t'(1);
            6:       return POS_LIMIT;
            default: return NEG_LIMIT;
        endcase
    endfunction

    // Offers one point word and records its prediction once it is taken.
    task automatic send_point(input coord_t re, input coord_t im);
        escape_entry_t word;
        while ($urandom_range(99) < send_idle_pct)
        begin
            point_valid <= 1'b0;
            @(posedge clk);
        end
        point_valid <= 1'b1;
        point_re    <= re;
        point_im    <= im;
        @(posedge clk);
        while (!point_ready)
            @(posedge clk);
        word.re    = re;
        word.im    = im;
        word.count = escape_count_of(re, im);
        pending_counts.push_back(word);
        points_sent++;
        if (julia_sel == MODE_JULIA)
            julia_points++;
    endtask

    // Writes one register word; only called while the block is idle.
    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] reg_index,
                             input logic [COORD_WIDTH-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= reg_index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (reg_index)
            CFG_JULIA_MODE:      julia_sel  = data[0];
            CFG_ITERATION_LIMIT: iter_limit = data[COUNT_WIDTH-1:0];
            CFG_JULIA_C_RE:      julia_re   = data;
            CFG_JULIA_C_IM:      julia_im   = data;
            default:             ;
        endcase
        reg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        point_valid <= 1'b0;
        while (pending_counts.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // Reset settings: Mandelbrot mode, limit 256.
    task automatic test_reset_defaults();
        send_idle_pct  = 30;
        recv_stall_pct = 30;
        send_point('0, '0);
        send_point(NEG_LIMIT, NEG_LIMIT);
        send_point(POS_LIMIT, POS_LIMIT);
        send_point(-TWO_POS, '0);
        // The cusp at 0.25 creeps towards 0.5 and never escapes.
        send_point(to_fix(0.25), '0);
        send_point(to_fix(-0.75), to_fix(0.1));
        wait_drained();
    endtask

    // Julia mode with the reset constant, including starts on or outside |z| = 2.
    task automatic test_julia_start();
        write_reg(CFG_JULIA_MODE, 32'h0000_0001);
        send_point('0, '0);
        send_point(TWO_POS, '0);
        send_point(to_fix(1.5), to_fix(1.5));
        send_point(to_fix(-0.3), to_fix(0.2));
        send_point(NEG_LIMIT, POS_LIMIT);
        wait_drained();
    endtask

    task automatic test_register_extremes();
        // Zero limit, written directly and through the bits above the count width.
        write_reg(CFG_ITERATION_LIMIT, 32'h0000_0000);
        send_point('0, '0);
        wait_drained();
        write_reg(CFG_ITERATION_LIMIT, 32'h0001_0000);
        send_point(to_fix(0.1), '0);
        wait_drained();
        write_reg(CFG_ITERATION_LIMIT, 32'hFFFE_0001);
        send_point('0, '0);
        wait_drained();
        // Largest c in both directions: the first step saturates, the next escapes.
        write_reg(CFG_ITERATION_LIMIT, 32'h0000_000A);
        write_reg(CFG_JULIA_C_RE, 32'h7FFF_FFFF);
        write_reg(CFG_JULIA_C_IM, 32'h8000_0000);
        send_point(to_fix(1.0), '0);
        send_point('0, to_fix(1.0));
        send_point('0, '0);
        wait_drained();
        // Longest single run: Mandelbrot origin at the largest limit.
        write_reg(CFG_JULIA_MODE, 32'hFFFF_FFFE);
        write_reg(CFG_ITERATION_LIMIT, 32'h0000_FFFF);
        send_point('0, '0);
        wait_drained();
    endtask

    // Writes to unused indexes must leave the settings alone.
    task automatic test_unused_index();
        write_reg(CFG_ITERATION_LIMIT, 32'd20);
        write_reg(CFG_UNUSED_FIRST, 32'h0000_0001);
        write_reg(CFG_UNUSED_LAST, 32'hFFFF_FFFF);
        send_point(to_fix(-0.1), to_fix(0.65));
        send_point(to_fix(0.3), to_fix(-0.5));
        wait_drained();
    endtask

    // Receiver holds off while points keep coming, so the input stalls.
    task automatic test_backpressure();
        write_reg(CFG_ITERATION_LIMIT, 32'd12);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req <= hold_req + 1;
        repeat (6)
            send_point(rand_coord(), rand_coord());
        wait_drained();
    endtask

    // Random points in blocks, with fresh register settings between blocks.
    task automatic run_phase(input int idle_pct, input int stall_pct, input int n_points);
        int                     sent;
        int                     block_len;
        int unsigned            pick;
        logic [COORD_WIDTH-1:0] noise;
        count_t                 lim;
        coord_t                 c_re;
        coord_t                 c_im;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_points)
        begin
            noise = $urandom;
            write_reg(CFG_JULIA_MODE, {noise[COORD_WIDTH-1:1], 1'($urandom_range(1))});

            // Mostly short limits; a few long ones and the odd zero.
            pick = $urandom_range(99);
            if (pick < 2)
                lim = '0;
            else if (pick < 80)
                lim = COUNT_WIDTH'($urandom_range(1, 40));
            else
                lim = COUNT_WIDTH'($urandom_range(41, 300));
            noise = $urandom;
            write_reg(CFG_ITERATION_LIMIT, {noise[COORD_WIDTH-1:COUNT_WIDTH], lim});

            // Julia constants near the set boundary, random small ones, or anything.
            case ($urandom_range(9))
                0:       begin c_re = to_fix(-0.8);     c_im = to_fix(0.156);   end
                1:       begin c_re = to_fix(0.285);    c_im = to_fix(0.01);    end
                2:       begin c_re = to_fix(-0.4);     c_im = to_fix(0.6);     end
                3:       begin c_re = to_fix(-0.70176); c_im = to_fix(-0.3842); end
                4:       begin c_re = to_fix(0.355);    c_im = to_fix(0.355);   end
                5:       begin c_re = to_fix(-0.123);   c_im = to_fix(0.745);   end
                6, 7, 8: begin c_re = coord_t'($urandom) >>> 3;
                               c_im = coord_t'($urandom) >>> 3; end
                default: begin c_re = coord_t'($urandom); c_im = coord_t'($urandom); end
            endcase
            write_reg(CFG_JULIA_C_RE, c_re);
            write_reg(CFG_JULIA_C_IM, c_im);
            if ($urandom_range(9) == 0)
                write_reg(CFG_INDEX_WIDTH'($urandom_range(4, 255)), $urandom);

            block_len = $urandom_range(20, 60);
            repeat (block_len)
                send_point(rand_coord(), rand_coord());
            sent += block_len;
            wait_drained();
        end
    endtask

    task automatic test_random_traffic();
        run_phase(0, 0, 420);
        run_phase(82, 0, 420);
        run_phase(0, 82, 420);
        run_phase(15, 15, 420);
    endtask

    // Test sequence.
    initial
    begin : main_seq
        escape_entry_t leftover;
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_julia_start();
        test_register_extremes();
        test_unused_index();
        test_backpressure();
        test_random_traffic();

        wait_drained();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        while (pending_counts.size() != 0)
        begin
            leftover = pending_counts.pop_front();
            report_fault($sformatf("point (%0d, %0d): count %0d never arrived",
                                   leftover.re, leftover.im, leftover.count));
        end

        $display("Checked %0d points (%0d in Julia mode) across %0d register writes.",
                 points_sent, julia_points, reg_writes);
        $display("Longest escape count %0d; %0d mismatches under idle, stall and hold-off.",
                 max_count_seen, error_count);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ quadratic_escape_time.f @@
src/qet_pkg.sv
src/qet_mul.sv
src/qet_core.sv
src/quadratic_escape_time.sv
sim/tb.sv
